// ----- hw/rtl/unordered_buffer_table_macros.svh -----
// Assertion helpers for the RTL file that carries checks.
`ifndef UNORDERED_BUFFER_TABLE_MACROS_SVH
`define UNORDERED_BUFFER_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("unordered_buffer_table: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define UBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("unordered_buffer_table: check failed");

`endif

// ----- hw/rtl/ubt_pkg.sv -----
package ubt_pkg;

  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = 5;
  localparam int VAL_W    = 32;

  typedef enum logic [1:0] {
    CMD_INSERT        = 2'd0,
    CMD_SWAP_REMOVE   = 2'd1,
    CMD_STABLE_REMOVE = 2'd2,
    CMD_FIND          = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_EXEC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic search;
    logic exec;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } stat_t;

endpackage

// ----- hw/rtl/ubt_ctrl.sv -----
module ubt_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ubt_pkg::stat_t stat_i,
  output ubt_pkg::ctrl_t ctrl_o
);

  ubt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ubt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_ready_o    = 1'b0;
    ctrl_o        = '0;
    case (state_q)
      ubt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = ubt_pkg::ST_SEARCH;
        end
      end
      ubt_pkg::ST_SEARCH: begin
        ctrl_o.search = 1'b1;
        state_d       = ubt_pkg::ST_EXEC;
      end
      ubt_pkg::ST_EXEC: begin
        // The update waits until the output register can take the result.
        if (!stat_i.out_blocked) begin
          ctrl_o.exec = 1'b1;
          in_ready_o  = 1'b1;
          if (in_valid_i) begin
            ctrl_o.load = 1'b1;
            state_d     = ubt_pkg::ST_SEARCH;
          end else begin
            state_d = ubt_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ubt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ubt_datapath.sv -----
module ubt_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ubt_pkg::ctrl_t                      ctrl_i,
  output ubt_pkg::stat_t                      stat_o,
  input  logic [1:0]                          cmd_i,
  input  logic signed [ubt_pkg::VAL_W-1:0]    value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                success_o,
  output logic [ubt_pkg::CNT_W-1:0]           entry_count_o
);

  localparam int N = ubt_pkg::CAPACITY;

  ubt_pkg::cmd_e                     cmd_q;
  logic signed [ubt_pkg::VAL_W-1:0]  value_q;
  logic [ubt_pkg::VAL_W-1:0]         entries_q [N];
  logic [ubt_pkg::VAL_W-1:0]         entries_d [N];
  logic [ubt_pkg::CNT_W-1:0]         count_q, count_d;
  logic [N-1:0]                      match, first, at_or_above;
  logic [N-1:0]                      hit_q, ge_q;
  logic                              found_q;
  logic [ubt_pkg::VAL_W-1:0]         last_q;
  logic [ubt_pkg::IDX_W-1:0]         last_idx;
  logic                              out_valid_q;
  logic                              success_q, success_d;
  logic [ubt_pkg::CNT_W-1:0]         out_count_q;
  logic                              not_full;

  // Compare the request value against every valid entry at once.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      match[i] = (ubt_pkg::CNT_W'(i) < count_q) &&
                 (entries_q[i] == ubt_pkg::VAL_W'(value_q));
    end
    first       = match & (~match + N'(1));
    // Every slot from the first match upward; empty when nothing matched.
    at_or_above = ~(first - N'(1));
    last_idx    = ubt_pkg::IDX_W'(count_q - ubt_pkg::CNT_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= ubt_pkg::cmd_e'(cmd_i);
      value_q <= value_i;
    end
    if (ctrl_i.search) begin
      hit_q   <= first;
      ge_q    <= at_or_above;
      found_q <= |match;
      last_q  <= entries_q[last_idx];
    end
  end

  assign not_full = count_q < ubt_pkg::CNT_W'(N);

  always_comb begin
    entries_d = entries_q;
    count_d   = count_q;
    success_d = 1'b0;
    case (cmd_q)
      ubt_pkg::CMD_INSERT: begin
        success_d = not_full;
        if (not_full) begin
          count_d = count_q + ubt_pkg::CNT_W'(1);
          for (int i = 0; i < N; i++) begin
            if (count_q[ubt_pkg::IDX_W-1:0] == ubt_pkg::IDX_W'(i)) begin
              entries_d[i] = ubt_pkg::VAL_W'(value_q);
            end
          end
        end
      end
      ubt_pkg::CMD_SWAP_REMOVE: begin
        success_d = found_q;
        if (found_q) begin
          count_d = count_q - ubt_pkg::CNT_W'(1);
          for (int i = 0; i < N; i++) begin
            if (hit_q[i]) begin
              entries_d[i] = last_q;
            end
          end
        end
      end
      ubt_pkg::CMD_STABLE_REMOVE: begin
        success_d = found_q;
        if (found_q) begin
          count_d = count_q - ubt_pkg::CNT_W'(1);
          for (int i = 0; i < N - 1; i++) begin
            if (ge_q[i] && (ubt_pkg::CNT_W'(i + 1) < count_q)) begin
              entries_d[i] = entries_q[i + 1];
            end
          end
        end
      end
      ubt_pkg::CMD_FIND: begin
        success_d = found_q;
      end
      default: begin
        success_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      entries_q   <= entries_d;
      success_q   <= success_d;
      out_count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl_i.exec) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_blocked = out_valid_q && !out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign success_o          = success_q;
  assign entry_count_o      = out_count_q;

endmodule

// ----- hw/rtl/unordered_buffer_table.sv -----
// Channel   Handshake                  Payload
// input     in_valid_i / in_ready_o    cmd_i[1:0], value_i[31:0] signed
// output    out_valid_o / out_ready_i  success_o, entry_count_o[4:0]
//
// A request passes through an accept cycle, then a search cycle that
// registers the compare of the value against all stored entries; the update
// and the result register are written once the output can take the result.
// Reset clears the controller state, the count and the output valid; entries need no clearing.
// A result waiting on out_ready_i holds the update step, and with it input.
`include "unordered_buffer_table_macros.svh"

module unordered_buffer_table (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [ubt_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              success_o,
  output logic [ubt_pkg::CNT_W-1:0]         entry_count_o
);

  ubt_pkg::ctrl_t ctrl;
  ubt_pkg::stat_t stat;
  logic           in_accept;
  logic           count_in_range;

  ubt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  ubt_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .cmd_i         (cmd_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .entry_count_o (entry_count_o)
  );

  assign in_accept      = in_valid_i && in_ready_o;
  assign count_in_range = entry_count_o <= ubt_pkg::CNT_W'(ubt_pkg::CAPACITY);

  // A pending result is never overwritten by the next update.
  `UBT_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, ctrl.exec, !out_valid_o || out_ready_i)
  // The cycle after an accept is always a search cycle that accepts no new request.
  `UBT_ASSERT_NXT(a_search_gap, clk_i, rst_ni, in_accept, !in_ready_o && ctrl.search)
  // The reported count stays within capacity.
  `UBT_ASSERT_IMP(a_count_range, clk_i, rst_ni, out_valid_o, count_in_range)

endmodule
